>>> rtl/core/gle_pkg.sv
// Shared types and constants for the GIF LZW encoder.
package gle_pkg;

    // Pixel is shifted by this much before the xor with the prefix when hashing
    localparam int HASH_SHIFT = 4;

    // Range of the LZW minimum code size after clamping
    localparam logic [3:0] MIN_SIZE_LO  = 4'd2;
    localparam logic [3:0] MIN_SIZE_HI  = 4'd8;
    localparam logic [3:0] MIN_SIZE_RST = 4'd2;

    typedef struct packed {
        logic [7:0] pixel;
        logic       last_pixel;
    } t_in;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_end;
        logic       image_end;
        logic       item_done;
    } t_out;

    // One datapath operation per cycle, chosen by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_SWEEP,
        OP_LOAD,
        OP_START,
        OP_LOOK,
        OP_PROBE,
        OP_HIT,
        OP_MISS,
        OP_PUT,
        OP_EMIT,
        OP_WIDTH,
        OP_INS,
        OP_FIRSTPFX,
        OP_LASTPFX,
        OP_ENDCODE,
        OP_FINISH,
        OP_DONE
    } t_op;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_START,
        S_LOOK,
        S_CMP,
        S_PUT,
        S_DRAIN,
        S_FIRST,
        S_INS,
        S_LASTCHK,
        S_ENDC,
        S_FLUSH,
        S_DONE
    } t_state;

    // Where to continue once a code has been packed and drained
    typedef enum logic [2:0] {
        RET_FIRST,
        RET_INS,
        RET_LAST,
        RET_END,
        RET_FLUSH
    } t_ret;

    typedef struct packed {
        logic started;
        logic last;
        logic hit;
        logic free;
        logic exhausted;
        logic full;
        logic bc_ge8;
        logic bc_nz;
        logic emit_ok;
        logic sweep_last;
    } t_sts;

endpackage

>>> rtl/core/gif_lzw_encoder_unit.sv
// Top level of the GIF LZW encoder: controller, datapath and dictionary RAM.
// Each item passes accept, hash read, compare, last-pixel check and hand-off on a
//   dictionary hit, plus a further read per extra probe, plus packing for each
//   code and a beat per byte; back-pressure stalls.
// Throughput: one item at a time; a new pixel is accepted only once the last item is done.
// Reset (synchronous, active low) starts a clearing pass that writes every slot
//   empty; the same pass runs after each image end and after each dictionary-full
//   clear, and no pixel beat is taken meanwhile.
module gif_lzw_encoder_unit #(
    parameter int HASH_SLOTS     = 5003,
    parameter int MAX_CODE_BITS  = 12,
    parameter int SUBBLOCK_BYTES = 254
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration: minimum code size
    input  logic          i_cfg_we,
    input  logic [3:0]    i_cfg_wdata,
    // pixel channel
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  gle_pkg::t_in  i_in_data,
    // byte channel
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output gle_pkg::t_out o_out_data
);
    import gle_pkg::*;

    // one datapath operation per cycle, and the status it reports back
    t_op  op;
    t_sts sts;

    // Sequence hashing, probing, code packing and byte drain.
    gle_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_sts     (sts),
        .o_op      (op)
    );

    // Hold the dictionary, the bit accumulator and the output register;
    // the last byte of an item waits in a holding stage so it can be tagged.
    gle_dp #(
        .HASH_SLOTS    (HASH_SLOTS),
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .SUBBLOCK_BYTES(SUBBLOCK_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_data  (i_in_data),
        .i_op       (op),
        .o_sts      (sts),
        .i_out_ready(i_out_ready),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data)
    );

endmodule

>>> rtl/core/gle_ram.sv
// Generic simple dual-port RAM with registered read.
module gle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/gle_ctrl.sv
// Controller state machine of the GIF LZW encoder.
module gle_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  gle_pkg::t_sts i_sts,
    output gle_pkg::t_op  o_op
);
    import gle_pkg::*;

    t_state r_state, n_state;
    t_ret   r_ret, n_ret;
    logic   r_need_sweep, n_need_sweep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_ret        <= RET_FIRST;
            r_need_sweep <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ret        <= n_ret;
            r_need_sweep <= n_need_sweep;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        n_need_sweep = r_need_sweep;
        o_op         = OP_NONE;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_SWEEP: begin
                o_op = OP_SWEEP;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_state = i_sts.started ? S_LOOK : S_START;
                end
            end
            S_START: begin
                o_op    = OP_START;
                n_ret   = RET_FIRST;
                n_state = S_PUT;
            end
            S_LOOK: begin
                o_op    = OP_LOOK;
                n_state = S_CMP;
            end
            S_CMP: begin
                priority if (i_sts.hit) begin
                    o_op    = OP_HIT;
                    n_state = S_LASTCHK;
                end else if (i_sts.free || i_sts.exhausted) begin
                    o_op    = OP_MISS;
                    n_ret   = RET_INS;
                    n_state = S_PUT;
                end else begin
                    o_op = OP_PROBE;
                end
            end
            S_PUT: begin
                o_op    = OP_PUT;
                n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (i_sts.bc_ge8) begin
                    if (i_sts.emit_ok) begin
                        o_op = OP_EMIT;
                    end
                end else begin
                    o_op = OP_WIDTH;
                    unique case (r_ret)
                        RET_FIRST: n_state = S_FIRST;
                        RET_INS:   n_state = S_INS;
                        RET_LAST:  n_state = S_LASTCHK;
                        RET_END:   n_state = S_ENDC;
                        RET_FLUSH: n_state = S_FLUSH;
                        default:   n_state = S_LASTCHK;
                    endcase
                end
            end
            S_FIRST: begin
                o_op    = OP_FIRSTPFX;
                n_state = S_LASTCHK;
            end
            S_INS: begin
                o_op = OP_INS;
                if (i_sts.full) begin
                    // dictionary full: send a clear code, wipe the table after the beat
                    n_need_sweep = 1'b1;
                    n_ret        = RET_LAST;
                    n_state      = S_PUT;
                end else begin
                    n_state = S_LASTCHK;
                end
            end
            S_LASTCHK: begin
                if (i_sts.last) begin
                    o_op    = OP_LASTPFX;
                    n_ret   = RET_END;
                    n_state = S_PUT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_ENDC: begin
                o_op    = OP_ENDCODE;
                n_ret   = RET_FLUSH;
                n_state = S_PUT;
            end
            S_FLUSH: begin
                if (i_sts.bc_nz) begin
                    if (i_sts.emit_ok) begin
                        o_op = OP_EMIT;
                    end
                end else begin
                    o_op    = OP_FINISH;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.emit_ok) begin
                    o_op         = OP_DONE;
                    n_need_sweep = 1'b0;
                    n_state      = (r_need_sweep || i_sts.last) ? S_SWEEP : S_IDLE;
                end
            end
            default: n_state = S_SWEEP;
        endcase
    end

endmodule

>>> rtl/core/gle_dp.sv
// Datapath of the GIF LZW encoder: dictionary, code packer and output stage.
module gle_dp #(
    parameter int HASH_SLOTS     = 5003,
    parameter int MAX_CODE_BITS  = 12,
    parameter int SUBBLOCK_BYTES = 254
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [3:0]    i_cfg_wdata,
    input  gle_pkg::t_in  i_in_data,
    input  gle_pkg::t_op  i_op,
    output gle_pkg::t_sts o_sts,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output gle_pkg::t_out o_out_data
);
    import gle_pkg::*;

    localparam int AW    = $clog2(HASH_SLOTS);
    localparam int CW    = MAX_CODE_BITS;
    localparam int KW    = 8 + CW;
    localparam int DW    = 1 + KW + CW;
    localparam int NW    = CW + 1;
    localparam int ACC_W = CW + 7;
    localparam int BCW   = $clog2(ACC_W + 1);

    function automatic logic [NW-1:0] f_lim(input logic [3:0] w);
        if (int'(w) >= CW) begin
            f_lim = NW'(1) << CW;
        end else begin
            f_lim = (NW'(1) << w) - NW'(1);
        end
    endfunction

    // control state
    logic [3:0]     r_cfg, n_cfg;
    logic [3:0]     r_min, n_min;
    logic [3:0]     r_cw, n_cw;
    logic [NW-1:0]  r_lim, n_lim;
    logic [NW-1:0]  r_nfc, n_nfc;
    logic [CW-1:0]  r_prefix, n_prefix;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [BCW-1:0] r_bc, n_bc;
    logic [7:0]     r_sbc, n_sbc;
    logic           r_clrp, n_clrp;
    logic           r_started, n_started;
    logic           r_last, n_last;
    logic           r_have, n_have;
    logic [AW-1:0]  r_n, n_n;
    logic [AW-1:0]  r_swp, n_swp;
    logic           r_pend_vld, n_pend_vld;
    logic           r_out_vld, n_out_vld;
    // payload
    logic [7:0]     r_pix, n_pix;
    logic [CW-1:0]  r_code, n_code;
    logic [KW-1:0]  r_key, n_key;
    logic [AW-1:0]  r_slot, n_slot;
    logic [AW-1:0]  r_disp, n_disp;
    t_out           r_pend, n_pend;
    t_out           r_out, n_out;

    logic [7:0]     pm_mask, pixm;
    logic [CW-1:0]  clr_code;
    logic [AW-1:0]  slot0, disp0, slot_next;
    logic [DW-1:0]  rdata, wdata;
    logic           rd_vld;
    logic [KW-1:0]  rd_key;
    logic [CW-1:0]  rd_code;
    logic           first, full, out_free, ram_we;
    logic [AW-1:0]  waddr, raddr;
    logic [3:0]     msz;
    logic [7:0]     sbc_inc;
    logic           be;
    t_out           emit_beat;

    always_comb begin
        pm_mask   = 8'hff >> (4'd8 - r_min);
        pixm      = r_pix & pm_mask;
        clr_code  = CW'(1) << r_min;
        slot0     = (AW'(pixm) << HASH_SHIFT) ^ AW'(r_prefix);
        disp0     = (slot0 == '0) ? AW'(1) : AW'(HASH_SLOTS) - slot0;
        slot_next = (r_slot >= r_disp) ? r_slot - r_disp
                                       : r_slot + (AW'(HASH_SLOTS) - r_disp);
        rd_vld    = rdata[DW-1];
        rd_key    = rdata[DW-2 -: KW];
        rd_code   = rdata[CW-1:0];
        first     = (r_n == '0);
        full      = (r_nfc >= (NW'(1) << CW));
        out_free  = !r_out_vld || i_out_ready;
        msz       = (r_cfg < MIN_SIZE_LO) ? MIN_SIZE_LO :
                    (r_cfg > MIN_SIZE_HI) ? MIN_SIZE_HI : r_cfg;
        sbc_inc   = r_sbc + 8'd1;
        be        = (int'(sbc_inc) >= SUBBLOCK_BYTES);
        emit_beat = '{data_byte: r_acc[7:0], block_end: be, image_end: 1'b0,
                      item_done: 1'b0};
    end

    always_comb begin
        o_sts.started    = r_started;
        o_sts.last       = r_last;
        o_sts.hit        = rd_vld && (rd_key == r_key);
        o_sts.free       = first ? !rd_vld : (!rd_vld || (rd_key == '0));
        o_sts.exhausted  = !first && (r_n == AW'(HASH_SLOTS));
        o_sts.full       = full;
        o_sts.bc_ge8     = (r_bc >= BCW'(8));
        o_sts.bc_nz      = (r_bc != '0);
        o_sts.emit_ok    = !r_pend_vld || out_free;
        o_sts.sweep_last = (r_swp == AW'(HASH_SLOTS - 1));
    end

    // dictionary table: {valid, key, code}
    always_comb begin
        ram_we = 1'b0;
        waddr  = r_slot;
        wdata  = {1'b1, r_key, r_nfc[CW-1:0]};
        raddr  = (i_op == OP_LOOK) ? slot0 : slot_next;
        if (i_op == OP_SWEEP) begin
            ram_we = 1'b1;
            waddr  = r_swp;
            wdata  = '0;
        end else if (i_op == OP_INS) begin
            ram_we = !full && r_have;
        end
    end

    gle_ram #(.WIDTH(DW), .DEPTH(HASH_SLOTS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_comb begin
        n_cfg      = i_cfg_we ? i_cfg_wdata : r_cfg;
        n_min      = r_min;
        n_cw       = r_cw;
        n_lim      = r_lim;
        n_nfc      = r_nfc;
        n_prefix   = r_prefix;
        n_acc      = r_acc;
        n_bc       = r_bc;
        n_sbc      = r_sbc;
        n_clrp     = r_clrp;
        n_started  = r_started;
        n_last     = r_last;
        n_have     = r_have;
        n_n        = r_n;
        n_swp      = r_swp;
        n_pend_vld = r_pend_vld;
        n_pix      = r_pix;
        n_code     = r_code;
        n_key      = r_key;
        n_slot     = r_slot;
        n_disp     = r_disp;
        n_pend     = r_pend;
        n_out      = r_out;
        n_out_vld  = i_out_ready ? 1'b0 : r_out_vld;
        unique case (i_op)
            OP_NONE: begin
            end
            OP_SWEEP: begin
                n_swp = (r_swp == AW'(HASH_SLOTS - 1)) ? '0 : r_swp + AW'(1);
            end
            OP_LOAD: begin
                n_pix  = i_in_data.pixel;
                n_last = i_in_data.last_pixel;
            end
            OP_START: begin
                n_min     = msz;
                n_cw      = msz + 4'd1;
                n_lim     = f_lim(msz + 4'd1);
                n_nfc     = (NW'(1) << msz) + NW'(2);
                n_acc     = '0;
                n_bc      = '0;
                n_sbc     = '0;
                n_clrp    = 1'b0;
                n_started = 1'b1;
                n_code    = CW'(1) << msz;
            end
            OP_LOOK: begin
                n_slot = slot0;
                n_disp = disp0;
                n_key  = {pixm, r_prefix};
                n_n    = '0;
            end
            OP_PROBE: begin
                n_slot = slot_next;
                n_n    = r_n + AW'(1);
            end
            OP_HIT: begin
                n_prefix = rd_code;
            end
            OP_MISS: begin
                n_have = o_sts.free;
                n_code = r_prefix;
            end
            OP_PUT: begin
                // keep only the pending bits, then append the code above them
                n_acc = (r_acc & ~({ACC_W{1'b1}} << r_bc)) | (ACC_W'(r_code) << r_bc);
                n_bc  = r_bc + BCW'(r_cw);
            end
            OP_EMIT: begin
                n_sbc      = be ? 8'd0 : sbc_inc;
                n_acc      = r_acc >> 8;
                n_bc       = (r_bc > BCW'(8)) ? r_bc - BCW'(8) : '0;
                n_pend     = emit_beat;
                n_pend_vld = 1'b1;
                if (r_pend_vld) begin
                    n_out     = r_pend;
                    n_out_vld = 1'b1;
                end
            end
            OP_WIDTH: begin
                if (r_clrp) begin
                    n_cw   = r_min + 4'd1;
                    n_lim  = f_lim(r_min + 4'd1);
                    n_clrp = 1'b0;
                end else if ((r_nfc > r_lim) && (int'(r_cw) < CW)) begin
                    n_cw  = r_cw + 4'd1;
                    n_lim = f_lim(r_cw + 4'd1);
                end
            end
            OP_INS: begin
                n_prefix = CW'(pixm);
                if (!full) begin
                    if (r_have) begin
                        n_nfc = r_nfc + NW'(1);
                    end
                end else begin
                    n_nfc  = NW'(clr_code) + NW'(2);
                    n_clrp = 1'b1;
                    n_code = clr_code;
                end
            end
            OP_FIRSTPFX: begin
                n_prefix = CW'(pixm);
            end
            OP_LASTPFX: begin
                n_code = r_prefix;
            end
            OP_ENDCODE: begin
                n_code = clr_code + CW'(1);
            end
            OP_FINISH: begin
                n_started = 1'b0;
                n_sbc     = '0;
                n_acc     = '0;
            end
            OP_DONE: begin
                // release the held beat as the item's final one
                if (r_pend_vld) begin
                    n_out           = r_pend;
                    n_out.item_done = 1'b1;
                    n_out.block_end = r_pend.block_end | r_last;
                    n_out.image_end = r_last;
                    n_out_vld       = 1'b1;
                    n_pend_vld      = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= MIN_SIZE_RST;
            r_min      <= MIN_SIZE_RST;
            r_cw       <= MIN_SIZE_RST + 4'd1;
            r_lim      <= f_lim(MIN_SIZE_RST + 4'd1);
            r_nfc      <= (NW'(1) << MIN_SIZE_RST) + NW'(2);
            r_prefix   <= '0;
            r_acc      <= '0;
            r_bc       <= '0;
            r_sbc      <= '0;
            r_clrp     <= 1'b0;
            r_started  <= 1'b0;
            r_last     <= 1'b0;
            r_have     <= 1'b0;
            r_n        <= '0;
            r_swp      <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_cfg      <= n_cfg;
            r_min      <= n_min;
            r_cw       <= n_cw;
            r_lim      <= n_lim;
            r_nfc      <= n_nfc;
            r_prefix   <= n_prefix;
            r_acc      <= n_acc;
            r_bc       <= n_bc;
            r_sbc      <= n_sbc;
            r_clrp     <= n_clrp;
            r_started  <= n_started;
            r_last     <= n_last;
            r_have     <= n_have;
            r_n        <= n_n;
            r_swp      <= n_swp;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix  <= n_pix;
        r_code <= n_code;
        r_key  <= n_key;
        r_slot <= n_slot;
        r_disp <= n_disp;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
